// ===== rtl/kmd_pkg.sv =====
package kmd_pkg;

  localparam int unsigned RowsDefault = 8;
  localparam int unsigned ColsDefault = 16;

  localparam int unsigned RowW  = 3;
  localparam int unsigned ColW  = 16;
  localparam int unsigned CntW  = 8;
  localparam int unsigned ThrW  = 8;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 3;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(5);

  typedef enum logic [0:0] {
    RegThreshold = 1'b0,
    RegNone      = 1'b1
  } reg_idx_e;

  typedef logic [CntW-1:0] cnt_t;

endpackage

// ===== rtl/key_matrix_debouncer.sv =====
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+---------------------------------------------
// in       | in_valid_i  | in_ready_o  | row_i, column_pressed_i
// out      | out_valid_o | out_ready_i | row_out_o, debounced_keys_o, pressed_edges_o,
//          |             |             | released_edges_o, any_down_o
// cfg      | psel/penable| pready      | paddr, pwdata, prdata
//
// Row memory read, then update and write-back. One row a cycle unless output stalls.
// Same-row back-to-back transactions forward the write-back data.
// Reset clears row valid bits, so unwritten rows read as zero; no clearing pass.
// A stalled output holds the update stage; input stalls only when both are full.
module key_matrix_debouncer
  import kmd_pkg::*;
#(
  parameter int unsigned ROWS = RowsDefault,
  parameter int unsigned COLS = ColsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [RowW-1:0]   row_i,
  input  logic [ColW-1:0]   column_pressed_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [RowW-1:0]   row_out_o,
  output logic [ColW-1:0]   debounced_keys_o,
  output logic [ColW-1:0]   pressed_edges_o,
  output logic [ColW-1:0]   released_edges_o,
  output logic              any_down_o,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  localparam int unsigned NRow = (ROWS < (2 ** RowW)) ? ROWS : (2 ** RowW);
  localparam int unsigned NCol = (COLS < ColW) ? COLS : ColW;
  localparam int unsigned RiW  = (NRow > 1) ? $clog2(NRow) : 1;
  localparam int unsigned EntW = NCol * (1 + CntW);

  logic [EntW-1:0] mem [NRow];

  logic [ThrW-1:0] thr_q;
  logic [NRow-1:0] rvld_q;
  logic [NRow-1:0] hkd_q, hkd_d;

  logic            s1_vld_q;
  logic [RowW-1:0] s1_row_q;
  logic [NCol-1:0] s1_raw_q;
  logic            s1_inr_q;
  logic [EntW-1:0] rd_q;
  logic            rv_q;
  logic            fwd_q;
  logic [EntW-1:0] fwd_data_q;

  logic            out_vld_q;
  logic [RowW-1:0] row_out_q;
  logic [ColW-1:0] keys_q, pe_q, re_q;
  logic            any_q;

  logic            in_acc, in_inr, s1_adv, s1_wr;
  logic [RiW-1:0]  in_idx, s1_idx;
  logic [EntW-1:0] cur, nxt;
  logic [NCol-1:0] prev, after;
  logic [ColW-1:0] keys_d, pe_d, re_d;
  logic            cfg_wr;

  // config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (reg_idx_e'(paddr[AddrW-1]) == RegThreshold);

  always_comb begin
    prdata = '0;
    if (reg_idx_e'(paddr[AddrW-1]) == RegThreshold) begin
      prdata[ThrW-1:0] = thr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_wr) begin
      thr_q <= pwdata[ThrW-1:0];
    end
  end

  // handshake
  assign s1_adv     = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_inr     = (int'(row_i) < int'(NRow));
  assign in_idx     = row_i[RiW-1:0];
  assign s1_idx     = s1_row_q[RiW-1:0];
  assign s1_wr      = s1_adv && s1_inr_q;

  // update stage
  always_comb begin
    cnt_t c_old, c_inc;
    cur    = fwd_q ? fwd_data_q : (rv_q ? rd_q : '0);
    prev   = cur[NCol-1:0];
    after  = prev;
    nxt    = cur;
    for (int c = 0; c < int'(NCol); c++) begin
      c_old = cur[NCol + c*CntW +: CntW];
      c_inc = (c_old == '1) ? c_old : c_old + cnt_t'(1);
      if (s1_raw_q[c] == prev[c]) begin
        nxt[NCol + c*CntW +: CntW] = '0;
      end else if (c_inc >= thr_q) begin
        after[c] = ~prev[c];
        nxt[NCol + c*CntW +: CntW] = '0;
      end else begin
        nxt[NCol + c*CntW +: CntW] = c_inc;
      end
    end
    nxt[NCol-1:0] = after;

    keys_d = '0;
    pe_d   = '0;
    re_d   = '0;
    hkd_d  = hkd_q;
    if (s1_inr_q) begin
      keys_d[NCol-1:0] = after;
      pe_d[NCol-1:0]   = after & ~prev;
      re_d[NCol-1:0]   = prev & ~after;
      hkd_d[s1_idx]    = |after;
    end
  end

  // row memory: registered read, write-back from update stage
  always_ff @(posedge clk_i) begin
    if (in_acc && in_inr) begin
      rd_q <= mem[in_idx];
    end
    if (s1_wr) begin
      mem[s1_idx] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      rvld_q   <= '0;
      hkd_q    <= '0;
      rv_q     <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
        rv_q     <= in_inr && rvld_q[in_idx];
        fwd_q    <= in_inr && s1_wr && (s1_idx == in_idx);
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_wr) begin
        rvld_q[s1_idx] <= 1'b1;
      end
      if (s1_adv) begin
        hkd_q <= hkd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_row_q <= row_i;
      s1_raw_q <= column_pressed_i[NCol-1:0];
      s1_inr_q <= in_inr;
      fwd_data_q <= nxt;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      row_out_q <= s1_row_q;
      keys_q    <= keys_d;
      pe_q      <= pe_d;
      re_q      <= re_d;
      any_q     <= |hkd_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign row_out_o        = row_out_q;
  assign debounced_keys_o = keys_q;
  assign pressed_edges_o  = pe_q;
  assign released_edges_o = re_q;
  assign any_down_o       = any_q;

`ifndef SYNTH
  a_fwd_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_acc) && fwd_q) |-> $past(s1_wr))
    else $error("forward flagged without write-back");

  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s1_vld_q))
    else $error("result without transaction in update stage");

  a_any_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (keys_q != '0)) |-> any_q)
    else $error("key down but any_down clear");

  a_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (((pe_q & re_q) == '0) && ((pe_q & ~keys_q) == '0)
                   && ((re_q & keys_q) == '0)))
    else $error("edge bits inconsistent with debounced state");
`endif

endmodule

// ===== sim/key_matrix_debouncer_tb.sv =====
`timescale 1ns / 1ps

module key_matrix_debouncer_tb;
  import kmd_pkg::*;

  localparam int unsigned Rows = RowsDefault;
  localparam int unsigned Cols = ColsDefault;
  localparam logic [AddrW-1:0] ThrAddr = AddrW'(4 * int'(RegThreshold));

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] keys;
    logic [ColW-1:0] pressed;
    logic [ColW-1:0] released;
    logic            any;
  } scan_t;

  typedef struct packed {
    logic            chk;
    logic [ColW-1:0] cols;
    scan_t           res;
  } dir_t;

  localparam int unsigned NumDir = 24;
  localparam dir_t Directed [NumDir] = '{
    '{1'b1, 16'h0000, '{3'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b1, 16'hFFFF, '{3'd7, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b1, 16'hFFFF, '{3'd7, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b1, 16'hFFFF, '{3'd7, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b1, 16'hFFFF, '{3'd7, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b1, 16'hFFFF, '{3'd7, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1}},
    '{1'b0, 16'h0001, '{3'd3, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b1, 16'h0000, '{3'd7, 16'hFFFF, 16'h0000, 16'h0000, 1'b1}},
    '{1'b1, 16'h0000, '{3'd7, 16'hFFFF, 16'h0000, 16'h0000, 1'b1}},
    '{1'b1, 16'h0000, '{3'd7, 16'hFFFF, 16'h0000, 16'h0000, 1'b1}},
    '{1'b1, 16'h0000, '{3'd7, 16'hFFFF, 16'h0000, 16'h0000, 1'b1}},
    '{1'b1, 16'h0000, '{3'd7, 16'h0000, 16'h0000, 16'hFFFF, 1'b0}},
    '{1'b0, 16'h8000, '{3'd2, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 16'h8000, '{3'd2, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 16'h8000, '{3'd2, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 16'h0000, '{3'd2, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 16'h8000, '{3'd2, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 16'h8000, '{3'd2, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 16'h8000, '{3'd2, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 16'h8000, '{3'd2, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 16'h8000, '{3'd2, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 16'h5555, '{3'd1, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 16'hAAAA, '{3'd1, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 16'hFFFF, '{3'd5, 16'h0000, 16'h0000, 16'h0000, 1'b0}}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [RowW-1:0]   row_i = '0;
  logic [ColW-1:0]   column_pressed_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [RowW-1:0]   row_out_o;
  logic [ColW-1:0]   debounced_keys_o;
  logic [ColW-1:0]   pressed_edges_o;
  logic [ColW-1:0]   released_edges_o;
  logic              any_down_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // predictor state
  logic [ColW-1:0] db_keys [Rows];
  cnt_t            diff_cnt [Rows][Cols];
  logic [Rows-1:0] rows_down;
  logic [ThrW-1:0] thr_q;
  logic [ColW-1:0] held_keys [Rows];

  scan_t expected_scans [$];
  int    mismatches = 0;
  int    send_idle = 30;
  int    recv_idle = 57;

  key_matrix_debouncer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .row_i            (row_i),
    .column_pressed_i (column_pressed_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .row_out_o        (row_out_o),
    .debounced_keys_o (debounced_keys_o),
    .pressed_edges_o  (pressed_edges_o),
    .released_edges_o (released_edges_o),
    .any_down_o       (any_down_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic debounce_scan(input logic [RowW-1:0] r, input logic [ColW-1:0] raw,
                               output scan_t res);
    logic [ColW-1:0] prev;
    logic [ColW-1:0] nxt;
    res = '0;
    res.row = r;
    if (r >= Rows) begin
      res.any = |rows_down;
      return;
    end
    prev = db_keys[r];
    nxt = prev;
    for (int c = 0; c < Cols; c++) begin
      if (raw[c] == prev[c]) begin
        diff_cnt[r][c] = '0;
      end else begin
        if (diff_cnt[r][c] != '1) diff_cnt[r][c] = diff_cnt[r][c] + 1'b1;
        if (diff_cnt[r][c] >= thr_q) begin
          nxt[c] = ~nxt[c];
          diff_cnt[r][c] = '0;
        end
      end
    end
    db_keys[r] = nxt;
    rows_down[r] = |nxt;
    res.keys = nxt;
    res.pressed = nxt & ~prev;
    res.released = prev & ~nxt;
    res.any = |rows_down;
  endtask

  // called right after a falling edge; returns right after a falling edge once the scan is accepted
  task automatic send_scan(input logic [RowW-1:0] r, input logic [ColW-1:0] cols,
                           input logic chk, input scan_t typed);
    scan_t pred;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    row_i = r;
    column_pressed_i = cols;
    do @(posedge clk_i); while (!in_ready_o);
    debounce_scan(r, cols, pred);
    expected_scans.push_back(chk ? typed : pred);
    @(negedge clk_i);
  endtask

  task automatic wait_drained(input int extra);
    in_valid_i = 1'b0;
    while (expected_scans.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic thr_read();
    psel = 1'b1;
    pwrite = 1'b0;
    penable = 1'b0;
    paddr = ThrAddr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[ThrW-1:0] !== thr_q) begin
      $display("%0t threshold read: expected %0d actual %0d", $time, thr_q, prdata[ThrW-1:0]);
      mismatches++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic thr_write(input logic [ThrW-1:0] v);
    wait_drained(4);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ThrAddr;
    pwdata = $urandom();
    pwdata[ThrW-1:0] = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    thr_q = v;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    thr_read();
  endtask

  // held keys per row with occasional changes and contact bounce on top
  task automatic scan_phase(input int n, input int fixed_row, input int change_pct,
                            input int bounce_pct);
    logic [RowW-1:0] r;
    logic [ColW-1:0] s;
    if (fixed_row >= 0 && change_pct == 0) held_keys[fixed_row] = ~db_keys[fixed_row];
    for (int i = 0; i < n; i++) begin
      if (n >= 100 && i == n / 2) wait_drained(0);
      r = (fixed_row >= 0) ? RowW'(fixed_row) : RowW'($urandom_range(0, Rows - 1));
      if ($urandom_range(0, 99) < change_pct) begin
        if ($urandom_range(0, 3) == 0) held_keys[r] = ColW'($urandom());
        else held_keys[r] = held_keys[r] ^ (ColW'(1) << $urandom_range(0, ColW - 1));
      end
      s = held_keys[r];
      if ($urandom_range(0, 99) < bounce_pct) begin
        if ($urandom_range(0, 4) == 0) s = s ^ ColW'($urandom());
        else s = s ^ (ColW'(1) << $urandom_range(0, ColW - 1));
      end
      send_scan(r, s, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic check_field(input string name, input logic [ColW-1:0] e,
                             input logic [ColW-1:0] a);
    if (e !== a) begin
      $display("%0t %s: expected %h actual %h", $time, name, e, a);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_scans.size() == 0) begin
        $display("%0t unexpected transaction: expected none actual row %0d keys %h",
                 $time, row_out_o, debounced_keys_o);
        mismatches++;
      end else begin
        check_field("row_out", ColW'(expected_scans[0].row), ColW'(row_out_o));
        check_field("debounced_keys", expected_scans[0].keys, debounced_keys_o);
        check_field("pressed_edges", expected_scans[0].pressed, pressed_edges_o);
        check_field("released_edges", expected_scans[0].released, released_edges_o);
        check_field("any_down", ColW'(expected_scans[0].any), ColW'(any_down_o));
        void'(expected_scans.pop_front());
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    for (int r = 0; r < Rows; r++) begin
      db_keys[r] = '0;
      held_keys[r] = '0;
      for (int c = 0; c < Cols; c++) diff_cnt[r][c] = '0;
    end
    rows_down = '0;
    thr_q = ThrReset;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    thr_read();
    for (int i = 0; i < NumDir; i++) begin
      send_scan(Directed[i].res.row, Directed[i].cols, Directed[i].chk, Directed[i].res);
    end
    scan_phase(150, -1, 8, 15);
    thr_write(8'd1);
    scan_phase(100, -1, 8, 15);

    send_idle = 57;
    recv_idle = 30;
    thr_write(8'd0);
    scan_phase(100, -1, 8, 15);
    thr_write(8'd255);
    scan_phase(260, 4, 0, 0);

    send_idle = 0;
    recv_idle = 0;
    // threshold lowered below running counts
    thr_write(8'd200);
    scan_phase(30, 6, 0, 0);
    thr_write(8'd2);
    scan_phase(20, 6, 0, 0);
    thr_write(8'd3);
    scan_phase(150, -1, 8, 15);
    thr_write(ThrW'($urandom_range(1, 8)));
    scan_phase(100, -1, 8, 15);

    wait_drained(10);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kmd_pkg.sv
rtl/key_matrix_debouncer.sv
sim/key_matrix_debouncer_tb.sv
